FILE: hw/rtl/q2r_pkg.sv
// ----------------------------------------------------------------------------
// q2r_pkg
// Shared widths, payload types and pipeline records for the quaternion to
// rotation matrix converter.
// ----------------------------------------------------------------------------
package q2r_pkg;

  localparam int IN_W   = 16;
  localparam int OUT_W  = 16;
  localparam int MAG_W  = IN_W;
  localparam int PROD_W = 2 * MAG_W;
  localparam int D_W    = PROD_W + 2;
  localparam int S_W    = D_W + 1;
  localparam int R_W    = D_W + 1;
  localparam int Q_W    = OUT_W;
  localparam int N_ENT  = 9;
  localparam int N_PROD = 6;

  typedef logic [D_W-1:0] num_t;

  typedef struct packed {
    logic signed [IN_W-1:0] quat_w;
    logic signed [IN_W-1:0] quat_x;
    logic signed [IN_W-1:0] quat_y;
    logic signed [IN_W-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] m_r0c0;
    logic signed [OUT_W-1:0] m_r0c1;
    logic signed [OUT_W-1:0] m_r0c2;
    logic signed [OUT_W-1:0] m_r1c0;
    logic signed [OUT_W-1:0] m_r1c1;
    logic signed [OUT_W-1:0] m_r1c2;
    logic signed [OUT_W-1:0] m_r2c0;
    logic signed [OUT_W-1:0] m_r2c1;
    logic signed [OUT_W-1:0] m_r2c2;
    logic                    zero_norm;
  } mat_t;

  typedef struct packed {
    logic                   zero;
    num_t                   den;
    logic [N_ENT-1:0]       neg;
    num_t [N_ENT-1:0]       num;
  } frame_t;

  typedef struct packed {
    logic                         zero;
    num_t                         den;
    logic [N_ENT-1:0]             neg;
    logic [N_ENT-1:0][R_W-1:0]    rem;
    logic [N_ENT-1:0][Q_W-1:0]    quo;
  } div_t;

endpackage

FILE: hw/rtl/q2r_front.sv
// ----------------------------------------------------------------------------
// q2r_front
// Three register stages: sign and magnitude, products, then the squared norm
// and the nine signed numerators.
// ----------------------------------------------------------------------------
module q2r_front import q2r_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  quat_t  quat,
  output logic   frame_valid,
  output frame_t frame
);

  function automatic logic signed [S_W-1:0] sx(input logic [PROD_W-1:0] p);
    return $signed({{(S_W-PROD_W){1'b0}}, p});
  endfunction

  function automatic logic signed [S_W-1:0] term(input logic [PROD_W-1:0] p,
                                                  input logic n);
    return n ? -sx(p) : sx(p);
  endfunction

  logic                   v1, v2;
  logic [3:0]             sn1;
  logic [3:0][MAG_W-1:0]  mg1;
  logic [3:0][PROD_W-1:0] sq2;
  logic [N_PROD-1:0][PROD_W-1:0] pr2;
  logic [N_PROD-1:0]      ps2;
  logic [3:0]             sn_in;
  logic [3:0][MAG_W-1:0]  mg_in;
  logic signed [N_ENT-1:0][S_W-1:0] val;
  num_t                   den_next;
  frame_t                 frame_next;

  assign sn_in = {quat.quat_z[IN_W-1], quat.quat_y[IN_W-1],
                  quat.quat_x[IN_W-1], quat.quat_w[IN_W-1]};

  always_comb begin
    mg_in[0] = sn_in[0] ? MAG_W'(0) - quat.quat_w : quat.quat_w;
    mg_in[1] = sn_in[1] ? MAG_W'(0) - quat.quat_x : quat.quat_x;
    mg_in[2] = sn_in[2] ? MAG_W'(0) - quat.quat_y : quat.quat_y;
    mg_in[3] = sn_in[3] ? MAG_W'(0) - quat.quat_z : quat.quat_z;
  end

  always_comb begin
    den_next = D_W'(sq2[0]) + D_W'(sq2[1]) + D_W'(sq2[2]) + D_W'(sq2[3]);
    val[0] = sx(sq2[0]) + sx(sq2[1]) - sx(sq2[2]) - sx(sq2[3]);
    val[4] = sx(sq2[0]) + sx(sq2[2]) - sx(sq2[1]) - sx(sq2[3]);
    val[8] = sx(sq2[0]) + sx(sq2[3]) - sx(sq2[1]) - sx(sq2[2]);
    val[1] = (term(pr2[0], ps2[0]) - term(pr2[1], ps2[1])) <<< 1;
    val[2] = (term(pr2[2], ps2[2]) + term(pr2[3], ps2[3])) <<< 1;
    val[3] = (term(pr2[0], ps2[0]) + term(pr2[1], ps2[1])) <<< 1;
    val[5] = (term(pr2[4], ps2[4]) - term(pr2[5], ps2[5])) <<< 1;
    val[6] = (term(pr2[2], ps2[2]) - term(pr2[3], ps2[3])) <<< 1;
    val[7] = (term(pr2[4], ps2[4]) + term(pr2[5], ps2[5])) <<< 1;
    frame_next.zero = (den_next == '0);
    frame_next.den  = den_next;
    for (int l = 0; l < N_ENT; l++) begin
      frame_next.neg[l] = val[l][S_W-1];
      frame_next.num[l] = val[l][S_W-1] ? D_W'(-val[l]) : D_W'(val[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      frame_valid <= 1'b0;
    end else if (en) begin
      v1          <= in_valid;
      v2          <= v1;
      frame_valid <= v2;
      sn1         <= sn_in;
      mg1         <= mg_in;
      for (int k = 0; k < 4; k++) begin
        sq2[k] <= mg1[k] * mg1[k];
      end
      pr2[0] <= mg1[1] * mg1[2];
      pr2[1] <= mg1[3] * mg1[0];
      pr2[2] <= mg1[1] * mg1[3];
      pr2[3] <= mg1[2] * mg1[0];
      pr2[4] <= mg1[2] * mg1[3];
      pr2[5] <= mg1[1] * mg1[0];
      ps2[0] <= sn1[1] ^ sn1[2];
      ps2[1] <= sn1[3] ^ sn1[0];
      ps2[2] <= sn1[1] ^ sn1[3];
      ps2[3] <= sn1[2] ^ sn1[0];
      ps2[4] <= sn1[2] ^ sn1[3];
      ps2[5] <= sn1[1] ^ sn1[0];
      frame  <= frame_next;
    end
  end

endmodule

FILE: hw/rtl/q2r_divider.sv
// ----------------------------------------------------------------------------
// q2r_divider
// Nine-lane restoring divider, one quotient bit per register stage, all lanes
// sharing the squared norm as divisor.
// ----------------------------------------------------------------------------
module q2r_divider import q2r_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   frame_valid,
  input  frame_t frame,
  output logic   div_valid,
  output div_t   div
);

  div_t       st [Q_W+1];
  logic       vl [Q_W+1];

  always_comb begin
    vl[0]      = frame_valid;
    st[0].zero = frame.zero;
    st[0].den  = frame.den;
    st[0].neg  = frame.neg;
    for (int l = 0; l < N_ENT; l++) begin
      st[0].rem[l] = R_W'(frame.num[l]);
      st[0].quo[l] = '0;
    end
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    div_t nx;

    always_comb begin
      logic             ge;
      logic [R_W-1:0]   r;
      nx = st[s];
      for (int l = 0; l < N_ENT; l++) begin
        ge = st[s].rem[l] >= R_W'(st[s].den);
        r  = ge ? st[s].rem[l] - R_W'(st[s].den) : st[s].rem[l];
        nx.rem[l] = {r[R_W-2:0], 1'b0};
        nx.quo[l] = {st[s].quo[l][Q_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[s+1] <= 1'b0;
      end else if (en) begin
        vl[s+1] <= vl[s];
        st[s+1] <= nx;
      end
    end
  end

  assign div_valid = vl[Q_W];
  assign div       = st[Q_W];

endmodule

FILE: hw/rtl/quaternion_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Converts a Q2.13 quaternion of any length into a row-major Q1.14 matrix.
// ----------------------------------------------------------------------------
// The block takes one quaternion per clock while the result side is not
// stalled: three front stages form the products and numerators, a 16-stage
// restoring divider produces one quotient bit per stage against the squared
// norm, and a final register rounds, saturates and signs the entries. A stall
// on the result side holds the whole pipeline, and every transaction in
// flight is kept. A zero quaternion returns zero entries with zero_norm set.
module quaternion_to_rotation_matrix import q2r_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  quat_valid,
  output logic  quat_stall,
  input  quat_t quat,
  output logic  mat_valid,
  input  logic  mat_stall,
  output mat_t  mat
);

  localparam logic [Q_W-1:0] LIM = Q_W'(1) << (OUT_W - 2);

  logic   en;
  logic   frame_valid, div_valid;
  frame_t frame;
  div_t   div;
  logic [N_ENT-1:0][OUT_W-1:0] ent;
  mat_t   mat_next;

  assign en         = !(mat_valid && mat_stall);
  assign quat_stall = !en;

  q2r_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(quat_valid && en), .quat(quat),
    .frame_valid(frame_valid), .frame(frame)
  );

  q2r_divider u_div (
    .clk(clk), .rst(rst), .en(en),
    .frame_valid(frame_valid), .frame(frame),
    .div_valid(div_valid), .div(div)
  );

  always_comb begin
    logic [Q_W:0]   rq;
    logic [Q_W-1:0] q;
    for (int l = 0; l < N_ENT; l++) begin
      rq = ({1'b0, div.quo[l]} + (Q_W+1)'(1)) >> 1;
      q  = (rq > (Q_W+1)'(LIM)) ? LIM : rq[Q_W-1:0];
      if (div.zero) begin
        ent[l] = '0;
      end else begin
        ent[l] = div.neg[l] ? OUT_W'(-q) : OUT_W'(q);
      end
    end
    mat_next.m_r0c0    = ent[0];
    mat_next.m_r0c1    = ent[1];
    mat_next.m_r0c2    = ent[2];
    mat_next.m_r1c0    = ent[3];
    mat_next.m_r1c1    = ent[4];
    mat_next.m_r1c2    = ent[5];
    mat_next.m_r2c0    = ent[6];
    mat_next.m_r2c1    = ent[7];
    mat_next.m_r2c2    = ent[8];
    mat_next.zero_norm = div.zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mat_valid <= 1'b0;
    end else if (en) begin
      mat_valid <= div_valid;
      mat       <= mat_next;
    end
  end

  a_zero_clears: assert property (@(posedge clk) disable iff (rst)
    mat_valid && mat.zero_norm |-> mat.m_r0c0 == '0 && mat.m_r1c1 == '0 &&
      mat.m_r2c2 == '0 && mat.m_r0c1 == '0 && mat.m_r2c0 == '0)
    else $error("zero quaternion gave a nonzero entry");

  a_diag_range: assert property (@(posedge clk) disable iff (rst)
    mat_valid |-> mat.m_r0c0 <= $signed(OUT_W'(LIM)) &&
      mat.m_r0c0 >= -$signed(OUT_W'(LIM)))
    else $error("diagonal entry out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    $past(mat_valid && mat_stall) && !$past(rst) |-> !$past(en))
    else $error("pipeline advanced under stall");

endmodule

FILE: sim/quaternion_to_rotation_matrix_tb.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_tb
// Streams quaternions through the converter under random idling on both
// sides and checks every matrix entry and the zero flag against a predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module quaternion_to_rotation_matrix_tb;
  import q2r_pkg::*;

  class matrix_scoreboard;
    mat_t pending[$];
    int   errors;
    int   checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    static function logic signed [15:0] ratio(logic signed [40:0] num, int shift,
                                              logic [39:0] den);
      logic [79:0] n;
      logic [79:0] q;
      logic        neg;
      neg = num < 0;
      n   = neg ? -num : num;
      q   = ((n << (shift + 1)) / den + 1) >> 1;
      if (q > 16384) q = 16384;
      return neg ? -q[15:0] : q[15:0];
    endfunction

    function void note_quat(quat_t q);
      logic signed [40:0] w, x, y, z, ww, xx, yy, zz;
      logic [39:0] d;
      mat_t m;
      w  = q.quat_w;
      x  = q.quat_x;
      y  = q.quat_y;
      z  = q.quat_z;
      ww = w * w;
      xx = x * x;
      yy = y * y;
      zz = z * z;
      d  = ww + xx + yy + zz;
      m  = '0;
      if (d == 0) begin
        m.zero_norm = 1'b1;
      end else begin
        m.m_r0c0 = ratio(xx + ww - yy - zz, 14, d);
        m.m_r1c1 = ratio(yy + ww - xx - zz, 14, d);
        m.m_r2c2 = ratio(zz + ww - xx - yy, 14, d);
        m.m_r0c1 = ratio(x * y - z * w, 15, d);
        m.m_r0c2 = ratio(x * z + y * w, 15, d);
        m.m_r1c0 = ratio(x * y + z * w, 15, d);
        m.m_r1c2 = ratio(y * z - x * w, 15, d);
        m.m_r2c0 = ratio(x * z - y * w, 15, d);
        m.m_r2c1 = ratio(y * z + x * w, 15, d);
      end
      pending.push_back(m);
    endfunction

    function void check_mat(mat_t a);
      mat_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("matrix transaction with no quaternion pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.m_r0c0 !== e.m_r0c0) begin
        $error("m_r0c0 expected %0d actual %0d", e.m_r0c0, a.m_r0c0); errors++;
      end
      if (a.m_r0c1 !== e.m_r0c1) begin
        $error("m_r0c1 expected %0d actual %0d", e.m_r0c1, a.m_r0c1); errors++;
      end
      if (a.m_r0c2 !== e.m_r0c2) begin
        $error("m_r0c2 expected %0d actual %0d", e.m_r0c2, a.m_r0c2); errors++;
      end
      if (a.m_r1c0 !== e.m_r1c0) begin
        $error("m_r1c0 expected %0d actual %0d", e.m_r1c0, a.m_r1c0); errors++;
      end
      if (a.m_r1c1 !== e.m_r1c1) begin
        $error("m_r1c1 expected %0d actual %0d", e.m_r1c1, a.m_r1c1); errors++;
      end
      if (a.m_r1c2 !== e.m_r1c2) begin
        $error("m_r1c2 expected %0d actual %0d", e.m_r1c2, a.m_r1c2); errors++;
      end
      if (a.m_r2c0 !== e.m_r2c0) begin
        $error("m_r2c0 expected %0d actual %0d", e.m_r2c0, a.m_r2c0); errors++;
      end
      if (a.m_r2c1 !== e.m_r2c1) begin
        $error("m_r2c1 expected %0d actual %0d", e.m_r2c1, a.m_r2c1); errors++;
      end
      if (a.m_r2c2 !== e.m_r2c2) begin
        $error("m_r2c2 expected %0d actual %0d", e.m_r2c2, a.m_r2c2); errors++;
      end
      if (a.zero_norm !== e.zero_norm) begin
        $error("zero_norm expected %0b actual %0b", e.zero_norm, a.zero_norm); errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG = 20000;

  logic  clk;
  logic  rst;
  logic  quat_valid;
  logic  quat_stall;
  quat_t quat;
  logic  mat_valid;
  logic  mat_stall;
  mat_t  mat;

  matrix_scoreboard sb;
  int send_idle;
  int recv_idle;
  int idle_cycles;
  int sent;

  quaternion_to_rotation_matrix i_dut (
    .clk        (clk),
    .rst        (rst),
    .quat_valid (quat_valid),
    .quat_stall (quat_stall),
    .quat       (quat),
    .mat_valid  (mat_valid),
    .mat_stall  (mat_stall),
    .mat        (mat)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      mat_stall <= 1'b0;
    end else begin
      mat_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && mat_valid && !mat_stall) sb.check_mat(mat);
  end

  always @(posedge clk) begin
    if (rst || (quat_valid && !quat_stall) || (mat_valid && !mat_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_quat(quat_t q);
    while ($urandom_range(99) < send_idle) begin
      quat_valid <= 1'b0;
      @(posedge clk);
    end
    quat_valid <= 1'b1;
    quat       <= q;
    @(posedge clk);
    while (quat_stall) @(posedge clk);
    sb.note_quat(q);
    sent++;
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(int count);
    quat_t q;
    repeat (count) begin
      q.quat_w = rand_comp();
      q.quat_x = rand_comp();
      q.quat_y = rand_comp();
      q.quat_z = rand_comp();
      if ($urandom_range(31) == 0) q = '0;
      send_quat(q);
    end
  endtask

  task automatic drain();
    quat_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    sb          = new();
    rst         = 1'b1;
    quat_valid  = 1'b0;
    quat        = '0;
    send_idle   = 0;
    recv_idle   = 0;
    sent        = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_quat('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
    send_quat('{16'sd8192, 16'sd0, 16'sd0, 16'sd0});
    send_quat('{16'sd0, 16'sd8192, 16'sd0, 16'sd0});
    send_quat('{16'sd0, 16'sd0, 16'sd8192, 16'sd0});
    send_quat('{16'sd0, 16'sd0, 16'sd0, 16'sd8192});
    send_quat('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    send_quat('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    send_quat('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
    send_quat('{16'sd1, 16'sd0, 16'sd0, 16'sd0});
    send_quat('{16'sd0, 16'sd0, 16'sd0, -16'sd1});
    send_quat('{16'sd1, 16'sd1, 16'sd1, 16'sd1});
    send_quat('{-16'sd1, 16'sd1, -16'sd1, 16'sd1});
    send_quat('{16'sd5793, 16'sd5793, 16'sd0, 16'sd0});
    send_quat('{16'sd5793, 16'sd0, -16'sd5793, 16'sd0});
    send_quat('{16'sd1, 16'sd2, 16'sd3, 16'sd4});
    send_quat('{16'sh8000, 16'sd0, 16'sd0, 16'sd1});
    drain();

    send_idle = 35;
    recv_idle = 60;
    send_random(550);
    drain();
    repeat (30) @(posedge clk);
    send_idle = 60;
    recv_idle = 35;
    send_random(550);
    send_idle = 0;
    recv_idle = 0;
    send_random(550);

    drain();
    repeat (30) @(posedge clk);
    $display("Sent %0d quaternions and checked %0d matrices, including zero, unit",
             sent, sb.checked);
    $display("and full-scale components under three idling patterns.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
